@@ sv/bdq_pkg.sv @@
package bdq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_POP_FRONT  = 3'd1;
  localparam action_t ACT_PUSH_BACK  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_ERASE      = 3'd4;

endpackage

@@ sv/bdq_ifs.sv @@
interface bdq_in_if;
  import bdq_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  value_t  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;
  logic   valid;
  logic   ready;
  count_t count;
  logic   is_empty;
  value_t head_value;
  value_t tail_value;
  count_t removed_count;
  logic   push_dropped;

  modport source (output valid, output count, output is_empty, output head_value,
                  output tail_value, output removed_count, output push_dropped,
                  input ready);
  modport sink   (input valid, input count, input is_empty, input head_value,
                  input tail_value, input removed_count, input push_dropped,
                  output ready);
endinterface

@@ sv/bdq_store.sv @@
module bdq_store
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  value_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output value_t                   rd_data
);

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bounded_deque_with_value_erase_top.sv @@
// Deque of signed 32-bit values kept as a ring in a single-port-write RAM.
// Flow: push, pop and no-op pass S_IDLE, S_RD_HEAD and S_RD_TAIL to S_REPORT, which
// registers the result once the output is free; an erase first scans in S_ERASE (one RAM
// read per stored entry, compacted in place). New input is accepted only in S_IDLE.
// Reset: count, ring head and handshake state clear; RAM contents are not cleared.
module bounded_deque_with_value_erase_top
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERASE,
    S_RD_HEAD,
    S_RD_TAIL,
    S_REPORT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] head_r;
  value_t        val_r;
  logic          drop_r;
  logic [CW-1:0] removed_r;
  logic [CW-1:0] kept_r;
  logic [CW-1:0] scan_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] wr_ptr_r;
  value_t        head_val_r;

  logic          out_valid_r;
  count_t        out_count_r;
  logic          out_empty_r;
  value_t        out_head_r;
  value_t        out_tail_r;
  count_t        out_removed_r;
  logic          out_drop_r;

  logic          in_fire;
  logic          out_load;
  logic [CW:0]   end_sum;
  logic [AW-1:0] end_addr;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          erase_hit;
  logic          erase_keep;
  logic [CW-1:0] kept_nxt;
  logic [CW-1:0] removed_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + 1'b1;
  endfunction

  bdq_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_load    = (state_r == S_REPORT) && (!out_valid_r || out_ch.ready);
  assign full        = (cnt_r == DEPTH_C);

  assign end_sum   = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign end_addr  = (end_sum >= DEPTH_S) ? AW'(end_sum - DEPTH_S) : AW'(end_sum);
  assign tail_addr = (end_addr == '0) ? LAST_A : end_addr - 1'b1;
  assign head_dec  = (head_r == '0) ? LAST_A : head_r - 1'b1;
  assign head_inc  = ptr_inc(head_r);

  assign erase_hit   = (state_r == S_ERASE) && (scan_r != '0) && (rd_data == val_r);
  assign erase_keep  = (state_r == S_ERASE) && (scan_r != '0) && (rd_data != val_r);
  assign kept_nxt    = erase_keep ? kept_r + 1'b1 : kept_r;
  assign removed_nxt = erase_hit ? removed_r + 1'b1 : removed_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr_r;
    wr_data = rd_data;
    if (in_fire && !full) begin
      case (in_ch.action)
        ACT_PUSH_FRONT: begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          wr_data = in_ch.value;
        end
        ACT_PUSH_BACK: begin
          wr_en   = 1'b1;
          wr_addr = end_addr;
          wr_data = in_ch.value;
        end
        default: ;
      endcase
    end else if (erase_keep) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    case (state_r)
      S_ERASE:   rd_addr = rd_ptr_r;
      S_RD_HEAD: rd_addr = head_r;
      default:   rd_addr = tail_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            val_r     <= in_ch.value;
            drop_r    <= full && (in_ch.action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK});
            removed_r <= '0;
            kept_r    <= '0;
            scan_r    <= '0;
            rd_ptr_r  <= head_r;
            wr_ptr_r  <= head_r;
            state_r   <= (in_ch.action == ACT_ERASE) ? S_ERASE : S_RD_HEAD;
            case (in_ch.action)
              ACT_PUSH_FRONT: begin
                if (!full) begin
                  head_r <= head_dec;
                  cnt_r  <= cnt_r + 1'b1;
                end
              end
              ACT_POP_FRONT: begin
                if (cnt_r != '0) begin
                  head_r <= head_inc;
                  cnt_r  <= cnt_r - 1'b1;
                end
              end
              ACT_PUSH_BACK: begin
                if (!full) begin
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              ACT_POP_BACK: begin
                if (cnt_r != '0) begin
                  cnt_r <= cnt_r - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_ERASE: begin
          kept_r    <= kept_nxt;
          removed_r <= removed_nxt;
          if (erase_keep) begin
            wr_ptr_r <= ptr_inc(wr_ptr_r);
          end
          if (scan_r == cnt_r) begin
            cnt_r   <= kept_nxt;
            state_r <= S_RD_HEAD;
          end else begin
            rd_ptr_r <= ptr_inc(rd_ptr_r);
            scan_r   <= scan_r + 1'b1;
          end
        end
        S_RD_HEAD: state_r <= S_RD_TAIL;
        S_RD_TAIL: begin
          head_val_r <= rd_data;
          state_r    <= S_REPORT;
        end
        S_REPORT: begin
          if (out_load) begin
            out_valid_r   <= 1'b1;
            out_count_r   <= COUNT_W'(cnt_r);
            out_empty_r   <= (cnt_r == '0);
            out_head_r    <= (cnt_r == '0) ? '0 : head_val_r;
            out_tail_r    <= (cnt_r == '0) ? '0 : rd_data;
            out_removed_r <= COUNT_W'(removed_r);
            out_drop_r    <= drop_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.count         = out_count_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.head_value    = out_head_r;
  assign out_ch.tail_value    = out_tail_r;
  assign out_ch.removed_count = out_removed_r;
  assign out_ch.push_dropped  = out_drop_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (in_ch.action == ACT_PUSH_FRONT || in_ch.action == ACT_PUSH_BACK))
      |=> drop_r && $stable(cnt_r))
    else $error("push on full store not dropped");

  a_erase_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERASE && scan_r != '0) |-> (kept_r + removed_r == scan_r - 1'b1))
    else $error("erase kept/removed tally mismatch");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(out_count_r))
    else $error("pending result overwritten");

endmodule

@@ sim/bounded_deque_with_value_erase_top_tb.sv @@
module bounded_deque_with_value_erase_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 32;

  // codes the block must treat as no-ops
  localparam action_t ACT_RSVD_5 = 3'd5;
  localparam action_t ACT_RSVD_6 = 3'd6;
  localparam action_t ACT_RSVD_7 = 3'd7;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    count_t count;
    logic   is_empty;
    value_t head_value;
    value_t tail_value;
    count_t removed_count;
    logic   push_dropped;
  } deque_status_t;

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_value_erase_top #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  value_t        deque_entries[$];
  deque_status_t status_expect_q[$];

  int mismatch_count  = 0;
  int sent_ops        = 0;
  int checked_results = 0;
  int erase_hits      = 0;
  int removed_total   = 0;
  int dropped_pushes  = 0;
  int cycle_count     = 0;

  int          gap_max    = 0;
  int          burst_left = 0;
  bit          stall_on   = 1'b0;
  logic [15:0] ready_pattern = 16'hffff;
  int          pattern_age   = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (!stall_on) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready  = ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age++;
      if (pattern_age >= 48) begin
        pattern_age   = 0;
        ready_pattern = 16'($urandom) | 16'h0001;
      end
    end
  end

  function automatic deque_status_t apply_deque_op(action_t act, value_t val);
    deque_status_t st;
    value_t        kept[$];
    int            removed;
    removed = 0;
    st.push_dropped = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (deque_entries.size() >= DEPTH) st.push_dropped = 1'b1;
        else deque_entries.insert(0, val);
      end
      ACT_POP_FRONT: begin
        if (deque_entries.size() > 0) deque_entries.delete(0);
      end
      ACT_PUSH_BACK: begin
        if (deque_entries.size() >= DEPTH) st.push_dropped = 1'b1;
        else deque_entries.push_back(val);
      end
      ACT_POP_BACK: begin
        if (deque_entries.size() > 0) void'(deque_entries.pop_back());
      end
      ACT_ERASE: begin
        foreach (deque_entries[i]) begin
          if (deque_entries[i] == val) removed++;
          else kept.push_back(deque_entries[i]);
        end
        deque_entries = kept;
      end
      default: ;
    endcase
    st.count         = count_t'(deque_entries.size());
    st.is_empty      = (deque_entries.size() == 0);
    st.head_value    = st.is_empty ? value_t'(0) : deque_entries[0];
    st.tail_value    = st.is_empty ? value_t'(0) : deque_entries[$];
    st.removed_count = count_t'(removed);
    if (removed > 0) erase_hits++;
    removed_total += removed;
    if (st.push_dropped) dropped_pushes++;
    return st;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_op(action_t act, value_t val);
    if (gap_max > 0 && burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.value  = val;
    do @(posedge clk); while (!in_ch.ready);
    status_expect_q.push_back(apply_deque_op(act, val));
    sent_ops++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    deque_status_t exp_st;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_expect_q.size() == 0) begin
        $error("result transaction with nothing expected: count=%0d head=%0d",
               out_ch.count, out_ch.head_value);
        mismatch_count++;
      end else begin
        exp_st = status_expect_q[0];
        status_expect_q.delete(0);
        checked_results++;
        if (out_ch.count !== exp_st.count) begin
          $error("count: expected %0d, got %0d", exp_st.count, out_ch.count);
          mismatch_count++;
        end
        if (out_ch.is_empty !== exp_st.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_st.is_empty, out_ch.is_empty);
          mismatch_count++;
        end
        if (out_ch.head_value !== exp_st.head_value) begin
          $error("head_value: expected %0d, got %0d", exp_st.head_value,
                 out_ch.head_value);
          mismatch_count++;
        end
        if (out_ch.tail_value !== exp_st.tail_value) begin
          $error("tail_value: expected %0d, got %0d", exp_st.tail_value,
                 out_ch.tail_value);
          mismatch_count++;
        end
        if (out_ch.removed_count !== exp_st.removed_count) begin
          $error("removed_count: expected %0d, got %0d", exp_st.removed_count,
                 out_ch.removed_count);
          mismatch_count++;
        end
        if (out_ch.push_dropped !== exp_st.push_dropped) begin
          $error("push_dropped: expected %0d, got %0d", exp_st.push_dropped,
                 out_ch.push_dropped);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             status_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // erase values are mostly taken from what is stored, so erases actually hit
  function automatic value_t pick_value(bit prefer_stored);
    int r;
    r = $urandom_range(0, 9);
    if (prefer_stored && deque_entries.size() > 0 && r < 6)
      return deque_entries[$urandom_range(0, deque_entries.size() - 1)];
    if (r < 6) return value_t'($urandom_range(0, 6)) - value_t'(3);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_MIN + value_t'(1);
        default: return VAL_MAX - value_t'(1);
      endcase
    end
    return value_t'($urandom);
  endfunction

  task automatic run_random(int n, int w_push, int w_pop, int w_erase);
    int      r;
    action_t act;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < w_push)
        act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else if (r < w_push + w_pop)
        act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
      else if (r < w_push + w_pop + w_erase)
        act = ACT_ERASE;
      else begin
        case ($urandom_range(0, 2))
          0:       act = ACT_RSVD_5;
          1:       act = ACT_RSVD_6;
          default: act = ACT_RSVD_7;
        endcase
      end
      send_op(act, pick_value(act == ACT_ERASE));
    end
  endtask

  task automatic test_empty_ops();
    send_op(ACT_POP_FRONT, value_t'(0));
    send_op(ACT_POP_BACK, value_t'(0));
    send_op(ACT_ERASE, value_t'(0));
    send_op(ACT_RSVD_5, VAL_MAX);
    send_op(ACT_RSVD_7, VAL_MIN);
  endtask

  task automatic test_extreme_values();
    send_op(ACT_PUSH_BACK, VAL_MIN);
    send_op(ACT_PUSH_FRONT, VAL_MAX);
    send_op(ACT_PUSH_BACK, value_t'(-1));
    send_op(ACT_PUSH_FRONT, value_t'(0));
    send_op(ACT_ERASE, VAL_MAX);
  endtask

  task automatic test_full_store();
    while (deque_entries.size() < DEPTH)
      send_op(deque_entries.size() % 2 ? ACT_PUSH_FRONT : ACT_PUSH_BACK, value_t'(7));
    send_op(ACT_PUSH_FRONT, value_t'(1));
    send_op(ACT_PUSH_BACK, value_t'(1));
    send_op(ACT_ERASE, value_t'(7));
  endtask

  task automatic test_random_mixed();
    gap_max  = 6;
    stall_on = 1'b1;
    run_random(500, 45, 35, 17);
  endtask

  task automatic test_fill_drain_cycles();
    for (int round = 0; round < 8; round++) begin
      gap_max  = (round < 3) ? 0 : 8;
      stall_on = (round >= 3);
      run_random(50, 85, 5, 7);
      run_random(30, 15, 60, 22);
    end
  endtask

  task automatic test_erase_heavy();
    gap_max  = 12;
    stall_on = 1'b1;
    run_random(480, 55, 10, 32);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PUSH_FRONT;
    in_ch.value  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    gap_max  = 3;
    stall_on = 1'b1;

    test_empty_ops();
    test_extreme_values();
    test_full_store();
    test_random_mixed();
    test_fill_drain_cycles();
    test_erase_heavy();

    in_ch.valid = 1'b0;
    while (status_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results checked in %0d cycles",
             sent_ops, checked_results, cycle_count);
    $display("%0d erases removed %0d entries, %0d pushes dropped on a full store",
             erase_hits, removed_total, dropped_pushes);
    if (mismatch_count == 0 && status_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bdq_pkg.sv
sv/bdq_ifs.sv
sv/bdq_store.sv
sv/bounded_deque_with_value_erase_top.sv
sim/bounded_deque_with_value_erase_top_tb.sv
